/* rtl/dtcc_pkg.sv */
// Shared types, codes and deflate length/distance code tables for the token classifier.
`default_nettype none
package dtcc_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 16;
    localparam int DIST_W   = 16;

    localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EOB     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OK_AFTER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SELECT_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOSEN_INDEX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_SELECT_ON = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOSEN_OFFSET    = 2'd3;

    localparam int NUM_LEN_CODES  = 29;
    localparam int NUM_DIST_CODES = 30;

    localparam logic [8:0] LEN_BASE [NUM_LEN_CODES] = '{
        9'd3,   9'd4,   9'd5,   9'd6,   9'd7,   9'd8,   9'd9,   9'd10,
        9'd11,  9'd13,  9'd15,  9'd17,  9'd19,  9'd23,  9'd27,  9'd31,
        9'd35,  9'd43,  9'd51,  9'd59,  9'd67,  9'd83,  9'd99,  9'd115,
        9'd131, 9'd163, 9'd195, 9'd227, 9'd258
    };
    localparam logic [2:0] LEN_EXTRA [NUM_LEN_CODES] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };

    localparam logic [14:0] DIST_BASE [NUM_DIST_CODES] = '{
        15'd1,     15'd2,     15'd3,     15'd4,     15'd5,     15'd7,
        15'd9,     15'd13,    15'd17,    15'd25,    15'd33,    15'd49,
        15'd65,    15'd97,    15'd129,   15'd193,   15'd257,   15'd385,
        15'd513,   15'd769,   15'd1025,  15'd1537,  15'd2049,  15'd3073,
        15'd4097,  15'd6145,  15'd8193,  15'd12289, 15'd16385, 15'd24577
    };
    localparam logic [3:0] DIST_EXTRA [NUM_DIST_CODES] = '{
        4'd0,  4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  4'd2,  4'd2,
        4'd3,  4'd3,  4'd4,  4'd4,  4'd5,  4'd5,  4'd6,  4'd6,
        4'd7,  4'd7,  4'd8,  4'd8,  4'd9,  4'd9,  4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
    };

    typedef struct packed {
        logic        ok;
        logic [8:0]  base;
        logic [2:0]  extra_bits;
        logic [4:0]  extra_value;
    } t_len_code;

    typedef struct packed {
        logic        ok;
        logic [14:0] base;
        logic [3:0]  extra_bits;
        logic [12:0] extra_value;
    } t_dist_code;

    typedef struct packed {
        logic       rejected;
        t_len_code  len;
        t_dist_code dcode;
        logic       overlaps;
    } t_match_info;

    function automatic t_len_code len_lookup(input logic [LEN_W-1:0] v);
        t_len_code   res;
        logic [LEN_W-1:0] lo;
        logic [LEN_W-1:0] hi;
        logic [LEN_W-1:0] diff;
        res = '0;
        for (int i = 0; i < NUM_LEN_CODES; i++) begin
            lo = LEN_W'(LEN_BASE[i]);
            hi = lo + ((LEN_W'(1) << LEN_EXTRA[i]) - LEN_W'(1));
            if (v >= lo && v <= hi) begin
                diff            = v - lo;
                res.ok          = 1'b1;
                res.base        = LEN_BASE[i];
                res.extra_bits  = LEN_EXTRA[i];
                res.extra_value = diff[4:0];
            end
        end
        return res;
    endfunction

    function automatic t_dist_code dist_lookup(input logic [DIST_W-1:0] v);
        t_dist_code  res;
        logic [DIST_W:0] lo;
        logic [DIST_W:0] hi;
        logic [DIST_W:0] diff;
        res = '0;
        for (int i = 0; i < NUM_DIST_CODES; i++) begin
            lo = (DIST_W+1)'(DIST_BASE[i]);
            hi = lo + (((DIST_W+1)'(1) << DIST_EXTRA[i]) - (DIST_W+1)'(1));
            if ({1'b0, v} >= lo && {1'b0, v} <= hi) begin
                diff            = {1'b0, v} - lo;
                res.ok          = 1'b1;
                res.base        = DIST_BASE[i];
                res.extra_bits  = DIST_EXTRA[i];
                res.extra_value = diff[12:0];
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/dtcc_code_map.sv */
// Match length/distance code mapping and copy overlap detection.
`default_nettype none
module dtcc_code_map (
    input  wire logic [dtcc_pkg::LEN_W-1:0]  i_match_len,
    input  wire logic [dtcc_pkg::DIST_W-1:0] i_match_dist,
    input  wire logic [dtcc_pkg::WORD_W-1:0] i_out_begin,
    input  wire logic [dtcc_pkg::WORD_W-1:0] i_out_end,
    output dtcc_pkg::t_match_info            o_info
);
    import dtcc_pkg::*;

    t_len_code  len_code;
    t_dist_code dist_code;
    logic       src_in_range;
    logic       range_nonempty;
    logic       len_past_dist;

    assign len_code  = len_lookup(i_match_len);
    assign dist_code = dist_lookup(i_match_dist);

    // source [begin-dist, +len) meets target [begin, end) when len exceeds dist
    assign src_in_range   = i_out_begin >= WORD_W'(i_match_dist);
    assign range_nonempty = i_out_end > i_out_begin;
    assign len_past_dist  = i_match_len > i_match_dist;

    always_comb begin
        o_info          = '0;
        o_info.rejected = !(len_code.ok && dist_code.ok);
        if (len_code.ok && dist_code.ok) begin
            o_info.len      = len_code;
            o_info.dcode    = dist_code;
            o_info.overlaps = src_in_range && range_nonempty && len_past_dist;
        end
    end

endmodule
`default_nettype wire

/* rtl/deflate_token_code_classifier.sv */
// Top level of the deflate token code classifier: input stage, classify, result stage.
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_stall   i_token_kind .. i_out_end
//  out      source     o_out_valid / i_out_stall o_path_kind .. o_offset_in_event
//  cfg      sink       i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// One token per cycle sustained while the output is not stalled.
// Latency is set by the input register and the result register around the code lookup.
// Synchronous active-low reset clears valids and the sticky error; configuration resets to 0.
// A stall on the output holds the result register, then the input register, then o_in_stall.
`default_nettype none
module deflate_token_code_classifier (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [dtcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dtcc_pkg::WORD_W-1:0]     i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [dtcc_pkg::KIND_W-1:0]     i_token_kind,
    input  wire logic [dtcc_pkg::WORD_W-1:0]     i_token_number,
    input  wire logic [dtcc_pkg::LEN_W-1:0]      i_match_len,
    input  wire logic [dtcc_pkg::DIST_W-1:0]     i_match_dist,
    input  wire logic [dtcc_pkg::WORD_W-1:0]     i_out_begin,
    input  wire logic [dtcc_pkg::WORD_W-1:0]     i_out_end,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [dtcc_pkg::KIND_W-1:0]          o_path_kind,
    output logic [dtcc_pkg::STATUS_W-1:0]        o_step_status,
    output logic [8:0]                           o_len_base,
    output logic [2:0]                           o_len_extra_bits,
    output logic [4:0]                           o_len_extra_value,
    output logic [14:0]                          o_dist_base,
    output logic [3:0]                           o_dist_extra_bits,
    output logic [12:0]                          o_dist_extra_value,
    output logic                                 o_copy_overlaps,
    output logic                                 o_is_selected,
    output logic                                 o_holds_offset,
    output logic [dtcc_pkg::WORD_W-1:0]          o_offset_in_event
);
    import dtcc_pkg::*;

    // configuration
    logic              r_index_select_on;
    logic [WORD_W-1:0] r_chosen_index;
    logic              r_offset_select_on;
    logic [WORD_W-1:0] r_chosen_offset;

    // input stage
    logic              r_s1_valid;
    logic [KIND_W-1:0] r_kind;
    logic [WORD_W-1:0] r_tnum;
    logic [LEN_W-1:0]  r_mlen;
    logic [DIST_W-1:0] r_mdist;
    logic [WORD_W-1:0] r_obeg;
    logic [WORD_W-1:0] r_oend;

    logic r_error_seen;
    logic n_error_seen;

    logic        in_xfer;
    logic        out_xfer;
    logic        s2_free;
    logic        s1_adv;
    logic        is_match;
    t_match_info info;

    logic [KIND_W-1:0]   n_path_kind;
    logic [STATUS_W-1:0] n_step_status;
    logic                n_is_selected;
    logic                n_holds_offset;
    logic [WORD_W-1:0]   n_offset_in_event;
    logic                reject;

    assign s2_free    = !o_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_select_on  <= 1'b0;
            r_chosen_index     <= '0;
            r_offset_select_on <= 1'b0;
            r_chosen_offset    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INDEX_SELECT_ON:  r_index_select_on  <= i_cfg_wdata[0];
                CFG_CHOSEN_INDEX:     r_chosen_index     <= i_cfg_wdata;
                CFG_OFFSET_SELECT_ON: r_offset_select_on <= i_cfg_wdata[0];
                CFG_CHOSEN_OFFSET:    r_chosen_offset    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind  <= i_token_kind;
            r_tnum  <= i_token_number;
            r_mlen  <= i_match_len;
            r_mdist <= i_match_dist;
            r_obeg  <= i_out_begin;
            r_oend  <= i_out_end;
        end
    end

    dtcc_code_map u_code_map (
        .i_match_len  (r_mlen),
        .i_match_dist (r_mdist),
        .i_out_begin  (r_obeg),
        .i_out_end    (r_oend),
        .o_info       (info)
    );

    always_comb begin
        is_match          = r_kind == KIND_MATCH;
        reject            = is_match && info.rejected;
        n_error_seen      = r_error_seen || (s1_adv && reject);
        case (r_kind)
            KIND_LITERAL: n_path_kind = KIND_LITERAL;
            KIND_MATCH:   n_path_kind = KIND_MATCH;
            default:      n_path_kind = KIND_EOB;
        endcase
        if (reject) begin
            n_step_status = ST_REJECT;
        end else if (r_error_seen) begin
            n_step_status = ST_OK_AFTER;
        end else begin
            n_step_status = ST_OK;
        end
        n_is_selected     = !reject && r_index_select_on && (r_chosen_index == r_tnum);
        n_holds_offset    = !reject && r_offset_select_on
                            && (r_chosen_offset >= r_obeg) && (r_chosen_offset < r_oend);
        n_offset_in_event = n_holds_offset ? (r_chosen_offset - r_obeg) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_seen <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            r_error_seen <= n_error_seen;
            if (s1_adv) begin
                o_out_valid <= 1'b1;
            end else if (out_xfer) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_path_kind       <= n_path_kind;
            o_step_status     <= n_step_status;
            o_is_selected     <= n_is_selected;
            o_holds_offset    <= n_holds_offset;
            o_offset_in_event <= n_offset_in_event;
            if (is_match) begin
                o_len_base         <= info.len.base;
                o_len_extra_bits   <= info.len.extra_bits;
                o_len_extra_value  <= info.len.extra_value;
                o_dist_base        <= info.dcode.base;
                o_dist_extra_bits  <= info.dcode.extra_bits;
                o_dist_extra_value <= info.dcode.extra_value;
                o_copy_overlaps    <= info.overlaps;
            end else begin
                o_len_base         <= '0;
                o_len_extra_bits   <= '0;
                o_len_extra_value  <= '0;
                o_dist_base        <= '0;
                o_dist_extra_bits  <= '0;
                o_dist_extra_value <= '0;
                o_copy_overlaps    <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* tb/sv/deflate_token_code_classifier_tb.sv */
// Testbench for deflate_token_code_classifier: directed table, then random tokens vs. predictor.
`timescale 1ns / 1ps
module deflate_token_code_classifier_tb;
    import dtcc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int TOKENS_PER_PHASE = 172;
    localparam int NUM_PHASES      = 6;

    localparam int LCODE_BASE [29] = '{
        3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
        35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258
    };
    localparam int LCODE_XB [29] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
        3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0
    };
    localparam int DCODE_BASE [30] = '{
        1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
        257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145, 8193, 12289,
        16385, 24577
    };
    localparam int DCODE_XB [30] = '{
        0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6, 6,
        7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] number;
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] distance;
        logic [WORD_W-1:0] obeg;
        logic [WORD_W-1:0] oend;
    } t_token;

    typedef struct packed {
        logic [KIND_W-1:0]   path;
        logic [STATUS_W-1:0] status;
        logic [8:0]          len_base;
        logic [2:0]          len_xbits;
        logic [4:0]          len_xval;
        logic [14:0]         dist_base;
        logic [3:0]          dist_xbits;
        logic [12:0]         dist_xval;
        logic                overlap;
        logic                selected;
        logic                holds;
        logic [WORD_W-1:0]   at_offset;
    } t_code_result;

    typedef struct packed {
        t_token       tok;
        logic         typed;
        t_code_result want;
    } t_stim_row;

    localparam t_code_result REJECTED = '{path: KIND_MATCH, status: ST_REJECT, default: '0};

    localparam int NUM_DIRECTED = 20;
    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{KIND_LITERAL, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0}, 1'b1,
          '{path: KIND_LITERAL, default: '0}},
        '{'{KIND_EOB, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{path: KIND_EOB, default: '0}},
        '{'{KIND_UNUSED, 32'h5A5A_5A5A, 16'd1234, 16'd999, 32'd10, 32'd20}, 1'b1,
          '{path: KIND_EOB, default: '0}},
        '{'{KIND_MATCH, 32'd3, 16'd3, 16'd1, 32'd100, 32'd103}, 1'b1,
          '{path: KIND_MATCH, len_base: 9'd3, dist_base: 15'd1, overlap: 1'b1, default: '0}},
        '{'{KIND_MATCH, 32'd4, 16'd258, 16'd32768, 32'd32768, 32'd33026}, 1'b1,
          '{path: KIND_MATCH, len_base: 9'd258, dist_base: 15'd24577, dist_xbits: 4'd13,
            dist_xval: 13'd8191, default: '0}},
        '{'{KIND_MATCH, 32'd5, 16'd257, 16'd24576, 32'd30000, 32'd30257}, 1'b0, '0},
        '{'{KIND_MATCH, 32'd6, 16'd227, 16'd16385, 32'd20000, 32'd20227}, 1'b0, '0},
        '{'{KIND_MATCH, 32'd7, 16'd10, 16'd4, 32'd2, 32'd12}, 1'b0, '0},
        '{'{KIND_MATCH, 32'd8, 16'd5, 16'd2, 32'd50, 32'd40}, 1'b0, '0},
        '{'{KIND_MATCH, 32'd9, 16'd11, 16'd5, 32'd1000, 32'd1011}, 1'b0, '0},
        '{'{KIND_MATCH, 32'd10, 16'd4, 16'd100, 32'd1000, 32'd1004}, 1'b0, '0},
        '{'{KIND_MATCH, 32'd11, 16'd258, 16'd1, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
        '{'{KIND_MATCH, 32'd12, 16'd2, 16'd1, 32'd5, 32'd7}, 1'b1, REJECTED},
        '{'{KIND_MATCH, 32'd13, 16'd259, 16'd1, 32'd5, 32'd264}, 1'b1, REJECTED},
        '{'{KIND_MATCH, 32'd14, 16'd3, 16'd0, 32'd5, 32'd8}, 1'b1, REJECTED},
        '{'{KIND_MATCH, 32'd15, 16'd3, 16'd32769, 32'd40000, 32'd40003}, 1'b1, REJECTED},
        '{'{KIND_MATCH, 32'd16, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          REJECTED},
        '{'{KIND_LITERAL, 32'd17, 16'd0, 16'd0, 32'd3, 32'd4}, 1'b1,
          '{path: KIND_LITERAL, status: ST_OK_AFTER, default: '0}},
        '{'{KIND_MATCH, 32'd18, 16'd18, 16'd7, 32'd64, 32'd82}, 1'b0, '0},
        '{'{KIND_MATCH, 32'd19, 16'd4, 16'd3, 32'd3, 32'd7}, 1'b0, '0}
    };

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [WORD_W-1:0]    i_cfg_wdata    = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [KIND_W-1:0]    i_token_kind   = '0;
    logic [WORD_W-1:0]    i_token_number = '0;
    logic [LEN_W-1:0]     i_match_len    = '0;
    logic [DIST_W-1:0]    i_match_dist   = '0;
    logic [WORD_W-1:0]    i_out_begin    = '0;
    logic [WORD_W-1:0]    i_out_end      = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [KIND_W-1:0]    o_path_kind;
    logic [STATUS_W-1:0]  o_step_status;
    logic [8:0]           o_len_base;
    logic [2:0]           o_len_extra_bits;
    logic [4:0]           o_len_extra_value;
    logic [14:0]          o_dist_base;
    logic [3:0]           o_dist_extra_bits;
    logic [12:0]          o_dist_extra_value;
    logic                 o_copy_overlaps;
    logic                 o_is_selected;
    logic                 o_holds_offset;
    logic [WORD_W-1:0]    o_offset_in_event;

    logic              error_latched = 1'b0;
    logic              index_on      = 1'b0;
    logic [WORD_W-1:0] chosen_idx    = '0;
    logic              offset_on     = 1'b0;
    logic [WORD_W-1:0] chosen_off    = '0;

    t_stim_row    token_backlog[$];
    t_code_result awaited_codes[$];
    t_stim_row    on_offer;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int phase_no    = 0;
    logic out_hold  = 1'b0;
    int cycle_count = 0;
    int mismatches  = 0;
    int tokens_sent = 0;
    int n_checked   = 0;
    int n_matches   = 0;
    int n_rejects   = 0;
    int n_overlaps  = 0;
    int n_selected  = 0;
    int n_holds     = 0;

    deflate_token_code_classifier u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_token_kind       (i_token_kind),
        .i_token_number     (i_token_number),
        .i_match_len        (i_match_len),
        .i_match_dist       (i_match_dist),
        .i_out_begin        (i_out_begin),
        .i_out_end          (i_out_end),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_path_kind        (o_path_kind),
        .o_step_status      (o_step_status),
        .o_len_base         (o_len_base),
        .o_len_extra_bits   (o_len_extra_bits),
        .o_len_extra_value  (o_len_extra_value),
        .o_dist_base        (o_dist_base),
        .o_dist_extra_bits  (o_dist_extra_bits),
        .o_dist_extra_value (o_dist_extra_value),
        .o_copy_overlaps    (o_copy_overlaps),
        .o_is_selected      (o_is_selected),
        .o_holds_offset     (o_holds_offset),
        .o_offset_in_event  (o_offset_in_event)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_code_result classify_token(input t_token t);
        t_code_result r;
        int li;
        int di;
        logic [63:0] src_lo;
        logic [63:0] src_hi;
        r = '0;
        li = -1;
        di = -1;
        if (t.kind == KIND_MATCH) begin
            r.path = KIND_MATCH;
            for (int i = 0; i < 29; i++) begin
                if (int'(t.len) >= LCODE_BASE[i]
                    && int'(t.len) < LCODE_BASE[i] + (1 << LCODE_XB[i]))
                    li = i;
            end
            for (int i = 0; i < 30; i++) begin
                if (int'(t.distance) >= DCODE_BASE[i]
                    && int'(t.distance) < DCODE_BASE[i] + (1 << DCODE_XB[i]))
                    di = i;
            end
            if (li < 0 || di < 0) begin
                error_latched = 1'b1;
                r.status = ST_REJECT;
                return r;
            end
            r.len_base   = 9'(LCODE_BASE[li]);
            r.len_xbits  = 3'(LCODE_XB[li]);
            r.len_xval   = 5'(int'(t.len) - LCODE_BASE[li]);
            r.dist_base  = 15'(DCODE_BASE[di]);
            r.dist_xbits = 4'(DCODE_XB[di]);
            r.dist_xval  = 13'(int'(t.distance) - DCODE_BASE[di]);
            if (t.obeg >= WORD_W'(t.distance)) begin
                src_lo = 64'(t.obeg) - 64'(t.distance);
                src_hi = src_lo + 64'(t.len);
                r.overlap = (src_hi > src_lo) && (t.oend > t.obeg)
                            && (src_lo < 64'(t.oend)) && (64'(t.obeg) < src_hi);
            end
        end else if (t.kind == KIND_LITERAL) begin
            r.path = KIND_LITERAL;
        end else begin
            r.path = KIND_EOB;
        end
        r.status = error_latched ? ST_OK_AFTER : ST_OK;
        r.selected = index_on && (chosen_idx == t.number);
        if (offset_on && chosen_off >= t.obeg && chosen_off < t.oend) begin
            r.holds = 1'b1;
            r.at_offset = chosen_off - t.obeg;
        end
        return r;
    endfunction

    function automatic t_token random_token();
        t_token t;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        t.kind = (pick < 55) ? KIND_MATCH : (pick < 82) ? KIND_LITERAL :
                 (pick < 95) ? KIND_EOB : KIND_UNUSED;
        pick = $urandom_range(0, 99);
        t.number = (pick < 20) ? chosen_idx : (pick < 25) ? chosen_idx + 1 : $urandom();
        t.len      = LEN_W'($urandom());
        t.distance = DIST_W'($urandom());
        if (t.kind == KIND_MATCH && $urandom_range(0, 99) < 92) begin
            t.len      = LEN_W'($urandom_range(3, 258));
            t.distance = DIST_W'($urandom_range(1, 1 << $urandom_range(1, 15)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)
            t.obeg = chosen_off - $urandom_range(0, 300);
        else if (pick < 70)
            t.obeg = $urandom_range(0, 40000);
        else
            t.obeg = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 70)
            t.oend = t.obeg + ((t.kind == KIND_MATCH) ? WORD_W'(t.len) : WORD_W'(1));
        else if (pick < 85)
            t.oend = t.obeg - $urandom_range(0, 20);
        else
            t.oend = $urandom();
        return t;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_INDEX_SELECT_ON:  index_on   = val[0];
            CFG_CHOSEN_INDEX:     chosen_idx = val;
            CFG_OFFSET_SELECT_ON: offset_on  = val[0];
            CFG_CHOSEN_OFFSET:    chosen_off = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (token_backlog.size() != 0 || i_in_valid || awaited_codes.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // offer tokens; hold the payload while stalled
    always @(posedge i_clk) begin
        logic held;
        t_code_result predicted;
        held = i_in_valid && o_in_stall;
        if (i_in_valid && !o_in_stall) begin
            predicted = classify_token(on_offer.tok);
            awaited_codes.insert(awaited_codes.size(),
                                 on_offer.typed ? on_offer.want : predicted);
            tokens_sent++;
        end
        if (!held) begin
            if (token_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                on_offer = token_backlog.pop_front();
                i_in_valid     <= 1'b1;
                i_token_kind   <= on_offer.tok.kind;
                i_token_number <= on_offer.tok.number;
                i_match_len    <= on_offer.tok.len;
                i_match_dist   <= on_offer.tok.distance;
                i_out_begin    <= on_offer.tok.obeg;
                i_out_end      <= on_offer.tok.oend;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_code_result got;
        t_code_result want;
        if (o_out_valid && !i_out_stall) begin
            got = {o_path_kind, o_step_status, o_len_base, o_len_extra_bits, o_len_extra_value,
                   o_dist_base, o_dist_extra_bits, o_dist_extra_value, o_copy_overlaps,
                   o_is_selected, o_holds_offset, o_offset_in_event};
            if (awaited_codes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
            end else begin
                want = awaited_codes.pop_front();
                check_field("path_kind", 32'(want.path), 32'(got.path));
                check_field("step_status", 32'(want.status), 32'(got.status));
                check_field("len_base", 32'(want.len_base), 32'(got.len_base));
                check_field("len_extra_bits", 32'(want.len_xbits), 32'(got.len_xbits));
                check_field("len_extra_value", 32'(want.len_xval), 32'(got.len_xval));
                check_field("dist_base", 32'(want.dist_base), 32'(got.dist_base));
                check_field("dist_extra_bits", 32'(want.dist_xbits), 32'(got.dist_xbits));
                check_field("dist_extra_value", 32'(want.dist_xval), 32'(got.dist_xval));
                check_field("copy_overlaps", 32'(want.overlap), 32'(got.overlap));
                check_field("is_selected", 32'(want.selected), 32'(got.selected));
                check_field("holds_offset", 32'(want.holds), 32'(got.holds));
                check_field("offset_in_event", want.at_offset, got.at_offset);
                n_checked++;
                n_matches  += int'(want.path == KIND_MATCH && want.status != ST_REJECT);
                n_rejects  += int'(want.status == ST_REJECT);
                n_overlaps += int'(want.overlap);
                n_selected += int'(want.selected);
                n_holds    += int'(want.holds);
            end
        end
        i_out_stall <= out_hold || ($urandom_range(0, 99) < rx_idle_pct);
    end

    // back up the output long enough to fill the block
    initial begin
        wait (phase_no == 5);
        repeat (10) @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, awaited_codes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic              sel_on;
        logic              off_on;
        logic [WORD_W-1:0] sel_val;
        logic [WORD_W-1:0] off_val;
        logic [WORD_W-1:0] wdata;
        t_stim_row         row;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        tx_idle_pct = 34;
        rx_idle_pct = 49;
        for (int r = 0; r < NUM_DIRECTED; r++)
            token_backlog.insert(token_backlog.size(), DIRECTED_ROWS[r]);
        wait_drained();

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            case (ph)
                1: begin sel_on = 1'b1; sel_val = '0; off_on = 1'b1; off_val = '0; end
                2: begin sel_on = 1'b1; sel_val = '1; off_on = 1'b1; off_val = '1; end
                3: begin
                    sel_on = 1'b1; sel_val = $urandom();
                    off_on = 1'b1; off_val = $urandom_range(0, 40000);
                end
                4: begin sel_on = 1'b0; sel_val = $urandom(); off_on = 1'b1; off_val = $urandom(); end
                5: begin
                    sel_on = 1'b1; sel_val = $urandom();
                    off_on = 1'b0; off_val = $urandom_range(0, 40000);
                end
                default: begin
                    sel_on = 1'b1; sel_val = $urandom_range(0, 1000);
                    off_on = 1'b1; off_val = $urandom_range(100, 5000);
                end
            endcase
            wdata = $urandom();
            wdata[0] = sel_on;
            write_reg(CFG_INDEX_SELECT_ON, wdata);
            write_reg(CFG_CHOSEN_INDEX, sel_val);
            wdata = $urandom();
            wdata[0] = off_on;
            write_reg(CFG_OFFSET_SELECT_ON, wdata);
            write_reg(CFG_CHOSEN_OFFSET, off_val);

            @(negedge i_clk);
            if (ph <= 2) begin
                tx_idle_pct = 34;
                rx_idle_pct = 49;
            end else if (ph <= 4) begin
                tx_idle_pct = 49;
                rx_idle_pct = 34;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            phase_no = ph;
            for (int n = 0; n < TOKENS_PER_PHASE; n++) begin
                row.tok   = random_token();
                row.typed = 1'b0;
                row.want  = '0;
                token_backlog.insert(token_backlog.size(), row);
            end
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        $display("Sent %0d tokens and checked %0d results: %0d valid matches, %0d rejected,",
                 tokens_sent, n_checked, n_matches, n_rejects);
        $display("%0d overlapping copies, %0d index hits, %0d offset hits over %0d settings",
                 n_overlaps, n_selected, n_holds, NUM_PHASES + 1);
        if (mismatches == 0 && awaited_codes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
